[hdl/fhp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR high-pass filter package
// Command codes, field widths and control bundles shared by the filter files.
// ----------------------------------------------------------------------------
package fhp_pkg;

	// Command field of an input word.
	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// Width of the coefficient index field; it sets how many taps are loadable.
	localparam int COEF_INDEX_W = 7;
	localparam int LOADABLE_TAPS = 1 << COEF_INDEX_W;

	// Per-cycle control that every tap cell sees.
	typedef struct packed {
		logic shift;   // a new sample enters the delay line
		logic rotate;  // both rings advance one cell toward the tail
	} fhp_cell_ctrl_t;

	// Control of the multiply-accumulate unit at the tail of the chain.
	typedef struct packed {
		logic clear;   // start a new sum
		logic mul_en;  // take a product of the tail cell this cycle
	} fhp_mac_ctrl_t;

endpackage
`default_nettype wire

[hdl/fhp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR high-pass filter channels
// Valid/ready channels for the input words and the filtered output words.
// ----------------------------------------------------------------------------
interface fhp_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                                    valid;
	logic                                    ready;
	logic                                    command;
	logic signed [SAMPLE_WIDTH-1:0]          sample_in;
	logic [fhp_pkg::COEF_INDEX_W-1:0]        coef_index;
	logic signed [SAMPLE_WIDTH-1:0]          coef_value;

	modport source (output valid, command, sample_in, coef_index, coef_value, input ready);
	modport sink (input valid, command, sample_in, coef_index, coef_value, output ready);
endinterface

interface fhp_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           saturated;

	modport source (output valid, sample_out, saturated, input ready);
	modport sink (input valid, sample_out, saturated, output ready);
endinterface
`default_nettype wire

[hdl/fhp_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR tap cell
// Holds one delayed sample and its coefficient and hands both to the next cell.
// ----------------------------------------------------------------------------
module fhp_cell #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire fhp_pkg::fhp_cell_ctrl_t        ctrl,
	input  wire logic                           load_en,
	input  wire logic signed [SAMPLE_WIDTH-1:0] hist_prev,
	input  wire logic signed [SAMPLE_WIDTH-1:0] coef_prev,
	input  wire logic signed [SAMPLE_WIDTH-1:0] load_value,
	output logic signed [SAMPLE_WIDTH-1:0]      hist,
	output logic signed [SAMPLE_WIDTH-1:0]      coef
);

	logic signed [SAMPLE_WIDTH-1:0] hist_q;
	logic signed [SAMPLE_WIDTH-1:0] coef_q;

	// The sample moves on both a shift-in and a rotation step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctrl.shift || ctrl.rotate) begin
			hist_q <= hist_prev;
		end
	end

	// The coefficient moves only while rotating; a load writes it in place.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (ctrl.rotate) begin
			coef_q <= coef_prev;
		end else if (load_en) begin
			coef_q <= load_value;
		end
	end

	assign hist = hist_q;
	assign coef = coef_q;

endmodule
`default_nettype wire

[hdl/fhp_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR multiply-accumulate unit
// Multiplies the tail cell's pair, sums the products, then rounds and clips.
// ----------------------------------------------------------------------------
module fhp_mac #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_W        = 39
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire fhp_pkg::fhp_mac_ctrl_t         ctrl,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_tail,
	input  wire logic signed [SAMPLE_WIDTH-1:0] coef_tail,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	output logic                                saturated
);

	localparam int PROD_W = 2 * SAMPLE_WIDTH;
	localparam logic signed [ACC_W-1:0] ROUND =
		{{(ACC_W-1){1'b0}}, 1'b1} << (SAMPLE_WIDTH - 2);
	localparam logic signed [ACC_W-1:0] MAXV =
		({{(ACC_W-1){1'b0}}, 1'b1} << (SAMPLE_WIDTH - 1)) - {{(ACC_W-1){1'b0}}, 1'b1};
	localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     prod_valid_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rounded;
	logic signed [ACC_W-1:0]  shifted;
	logic                     sat_hi;
	logic                     sat_lo;

	// Product register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s1 <= 1'b0;
		end else begin
			prod_valid_s1 <= ctrl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= sample_tail * coef_tail;
		end
	end

	// Accumulator; it wraps at its width, which is exact below the 64-bit cap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (prod_valid_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// Round half up, drop the fraction bits and clip to the sample range.
	always_comb begin
		rounded = acc_q + ROUND;
		shifted = rounded >>> (SAMPLE_WIDTH - 1);
		sat_hi  = shifted > MAXV;
		sat_lo  = shifted < MINV;
	end

	assign sample_out = sat_hi ? MAXV[SAMPLE_WIDTH-1:0] :
		(sat_lo ? MINV[SAMPLE_WIDTH-1:0] : shifted[SAMPLE_WIDTH-1:0]);
	assign saturated = sat_hi || sat_lo;

endmodule
`default_nettype wire

[hdl/fir_highpass_filter.sv]
// A sample word is taken while idle; the ring rotates in the run state, the sum
// settles in the drain state and the emit state waits for a free output register.
// The single multiplier at the ring's tail visits every cell once per sample; no
// word is taken until the sum is emitted. A coefficient load gives no output word.
// Reset clears the delay line and all coefficients to zero at once.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIR high-pass filter
// Direct-form FIR on a ring of tap cells that rotates past one MAC unit.
// ----------------------------------------------------------------------------
module fir_highpass_filter #(
	parameter int TAPS         = 128,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	fhp_in_if.sink    samples,
	fhp_out_if.source results
);

	localparam int CNT_W    = $clog2(TAPS);
	localparam int ACC_FULL = 2 * SAMPLE_WIDTH + $clog2(TAPS);
	localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           accept;
	logic                           accept_sample;
	logic                           accept_load;
	logic                           emit_go;
	fhp_pkg::fhp_cell_ctrl_t        cell_ctrl;
	fhp_pkg::fhp_mac_ctrl_t         mac_ctrl;
	logic signed [SAMPLE_WIDTH-1:0] hist_w [TAPS];
	logic signed [SAMPLE_WIDTH-1:0] coef_w [TAPS];
	logic [TAPS-1:0]                load_en;
	logic signed [SAMPLE_WIDTH-1:0] mac_sample;
	logic                           mac_sat;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
	logic                           out_sat_q;

	// Input handshake: words are taken only between sums.
	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign accept_sample = accept && (samples.command == fhp_pkg::CMD_FILTER);
	assign accept_load   = accept && (samples.command == fhp_pkg::CMD_LOAD);
	assign emit_go       = (state_q == ST_EMIT) && (!out_valid_q || results.ready);

	// Sequencer: shift in, rotate the ring TAPS times, let the sum settle, emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept_sample) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(TAPS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cell_ctrl.shift  = accept_sample;
		cell_ctrl.rotate = (state_q == ST_RUN);
		mac_ctrl.clear   = accept_sample;
		mac_ctrl.mul_en  = (state_q == ST_RUN);
	end

	// Ring of tap cells; cell 0 takes the new sample or the wrapped tail.
	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		logic signed [SAMPLE_WIDTH-1:0] hist_prev;
		logic signed [SAMPLE_WIDTH-1:0] coef_prev;

		if (k == 0) begin : g_head
			assign hist_prev = cell_ctrl.rotate ? hist_w[TAPS-1] : samples.sample_in;
			assign coef_prev = coef_w[TAPS-1];
		end else begin : g_body
			assign hist_prev = hist_w[k-1];
			assign coef_prev = coef_w[k-1];
		end

		// Only taps reachable by the index field can be loaded.
		if (k < fhp_pkg::LOADABLE_TAPS) begin : g_load
			localparam logic [fhp_pkg::COEF_INDEX_W-1:0] KIDX = fhp_pkg::COEF_INDEX_W'(k);
			assign load_en[k] = accept_load && (samples.coef_index == KIDX);
		end else begin : g_noload
			assign load_en[k] = 1'b0;
		end

		fhp_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.load_en   (load_en[k]),
			.hist_prev (hist_prev),
			.coef_prev (coef_prev),
			.load_value(samples.coef_value),
			.hist      (hist_w[k]),
			.coef      (coef_w[k])
		);
	end

	// MAC unit at the tail of the ring.
	fhp_mac #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.ACC_W       (ACC_W)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (mac_ctrl),
		.sample_tail(hist_w[TAPS-1]),
		.coef_tail  (coef_w[TAPS-1]),
		.sample_out (mac_sample),
		.saturated  (mac_sat)
	);

	// Output register; it holds a word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_sample_q <= mac_sample;
			out_sat_q    <= mac_sat;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.sample_out = out_sample_q;
	assign results.saturated  = out_sat_q;

	// An emit step always leaves a new output word in the output register.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && !out_valid_q) |=> out_valid_q)
		else $error("output word not registered after emit");

	// A sample word starts a ring rotation in the next cycle.
	a_sample_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept_sample |=> (state_q == ST_RUN) && (cnt_q == '0))
		else $error("sample word did not start a sum");

	// A load word produces no sum and leaves the block ready.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept_load |=> (state_q == ST_IDLE))
		else $error("coefficient load left the idle state");

	// The ring only rotates while the MAC is fed.
	a_rotate_mac: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctrl.rotate |=> $past(mac_ctrl.mul_en) && !$past(cell_ctrl.shift))
		else $error("ring rotated without a product being taken");

endmodule
`default_nettype wire

[tb/sv/fhp_filter_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR high-pass filter output check
// Watches both channels, keeps its own delay line and coefficient store,
// predicts every filtered word and compares it with what the block gives.
// ----------------------------------------------------------------------------
module fhp_filter_check #(
	parameter int TAPS         = 128,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	fhp_in_if    words_in,
	fhp_out_if   words_out,
	output int   error_count,
	output int   open_words,
	output int   saturations
);

	localparam int SW = SAMPLE_WIDTH;
	localparam longint OUT_MAX = (longint'(1) <<< (SW - 1)) - 1;
	localparam longint OUT_MIN = -(longint'(1) <<< (SW - 1));

	typedef struct packed {
		logic signed [SW-1:0] value;
		logic                 sat;
	} filt_word_t;

	logic signed [SW-1:0] delay_line [TAPS];
	logic signed [SW-1:0] coef_store [TAPS];
	filt_word_t           expected_outputs [$];
	int                   fails;
	int                   sat_count;

	assign error_count = fails;
	assign saturations = sat_count;

	// Shifts one sample in, forms the exact dot product, rounds half up,
	// drops the fraction bits and clips to the output range.
	function automatic filt_word_t filter_sample(input logic signed [SW-1:0] smp);
		longint acc;
		longint shifted;
		filt_word_t w;
		for (int k = TAPS - 1; k > 0; k--)
			delay_line[k] = delay_line[k-1];
		delay_line[0] = smp;
		acc = 0;
		for (int k = 0; k < TAPS; k++)
			acc += longint'(delay_line[k]) * longint'(coef_store[k]);
		acc += longint'(1) <<< (SW - 2);
		shifted = acc >>> (SW - 1);
		if (shifted > OUT_MAX) begin
			w.value = OUT_MAX[SW-1:0];
			w.sat   = 1'b1;
		end else if (shifted < OUT_MIN) begin
			w.value = OUT_MIN[SW-1:0];
			w.sat   = 1'b1;
		end else begin
			w.value = shifted[SW-1:0];
			w.sat   = 1'b0;
		end
		return w;
	endfunction

	// Output words are checked before the input word of the same edge is taken in.
	always @(posedge clk or negedge arst_n) begin
		filt_word_t want;
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				delay_line[k] = '0;
				coef_store[k] = '0;
			end
			expected_outputs.delete();
			fails      = 0;
			sat_count  = 0;
			open_words <= 0;
		end else begin
			if (words_out.valid && words_out.ready) begin
				if (expected_outputs.size() == 0) begin
					fails++;
					$display("%0t: output word expected none, got sample_out=%0d saturated=%0b",
						$time, words_out.sample_out, words_out.saturated);
				end else begin
					want = expected_outputs.pop_front();
					if (want.sat)
						sat_count++;
					if (words_out.sample_out !== want.value) begin
						fails++;
						$display("%0t: sample_out expected %0d, got %0d",
							$time, want.value, words_out.sample_out);
					end
					if (words_out.saturated !== want.sat) begin
						fails++;
						$display("%0t: saturated expected %0b, got %0b",
							$time, want.sat, words_out.saturated);
					end
				end
			end
			if (words_in.valid && words_in.ready) begin
				if (words_in.command == fhp_pkg::CMD_LOAD) begin
					// Indexes past the last tap are dropped.
					if (int'(words_in.coef_index) < TAPS)
						coef_store[words_in.coef_index] = words_in.coef_value;
				end else begin
					expected_outputs.push_back(filter_sample(words_in.sample_in));
				end
			end
			open_words <= expected_outputs.size();
		end
	end

endmodule

[tb/sv/tb_fir_highpass_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR high-pass filter testbench
// Drives coefficient loads and audio samples with random gaps and stalls,
// starting with hand-picked rounding and clipping cases, and leaves all
// prediction and comparison to the output check beside the block.
// ----------------------------------------------------------------------------
module tb_fir_highpass_filter;

	localparam int TAPS         = 128;
	localparam int SW           = 16;
	localparam int IW           = fhp_pkg::COEF_INDEX_W;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 1200;
	localparam int ROUND_WORDS  = 170;
	localparam int ROUND_LOADS  = 16;
	localparam logic signed [SW-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [SW-1:0] S_MIN = 16'sh8000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic steady = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   cycle_count = 0;
	int   errors;
	int   open_words;
	int   saturations;
	int   samples_sent = 0;
	int   loads_sent = 0;

	fhp_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
	fhp_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

	fir_highpass_filter #(
		.TAPS(TAPS),
		.SAMPLE_WIDTH(SW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.results(out_ch)
	);

	fhp_filter_check #(
		.TAPS(TAPS),
		.SAMPLE_WIDTH(SW)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.words_in(in_ch),
		.words_out(out_ch),
		.error_count(errors),
		.open_words(open_words),
		.saturations(saturations)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words outstanding",
				cycle_count, open_words);
			$display("fir_highpass_filter: mismatch");
			$finish;
		end
	end

	// Output side: random back-pressure, one long hold-off on request.
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ch.ready <= steady || ($urandom_range(99) >= 23);
			end
		end
	end

	// Offers one word, with a random gap before it, and waits until it is taken.
	task automatic send_word(input logic cmd, input logic [SW-1:0] smp,
			input logic [IW-1:0] idx, input logic [SW-1:0] cv);
		while (!steady && $urandom_range(99) < 23) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.command    <= cmd;
		in_ch.sample_in  <= smp;
		in_ch.coef_index <= idx;
		in_ch.coef_value <= cv;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (cmd == fhp_pkg::CMD_LOAD)
			loads_sent++;
		else
			samples_sent++;
	endtask

	task automatic send_sample(input logic [SW-1:0] smp);
		send_word(fhp_pkg::CMD_FILTER, smp, IW'($urandom), SW'($urandom));
	endtask

	task automatic load_coef(input logic [IW-1:0] idx, input logic [SW-1:0] cv);
		send_word(fhp_pkg::CMD_LOAD, SW'($urandom), idx, cv);
	endtask

	// Stops offering words until every filtered word has come back.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (open_words != 0);
	endtask

	// Full-scale extremes now and then, otherwise uniform.
	function automatic logic [SW-1:0] rand_sample();
		case ($urandom_range(9))
			0: return S_MIN;
			1: return S_MAX;
			default: return SW'($urandom);
		endcase
	endfunction

	// Small taps keep the sum in range, full-scale taps clip it,
	// and scaled taps land anywhere in between.
	function automatic logic [SW-1:0] rand_coef(input int style);
		logic signed [SW-1:0] v;
		v = SW'($urandom);
		case (style)
			0: return SW'($urandom_range(1023)) - 16'd512;
			1: return v;
			default: return v >>> $urandom_range(15);
		endcase
	endfunction

	initial begin
		int style;
		in_ch.valid      = 1'b0;
		in_ch.command    = fhp_pkg::CMD_FILTER;
		in_ch.sample_in  = '0;
		in_ch.coef_index = '0;
		in_ch.coef_value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Cleared coefficients give zero for any sample.
		send_sample(S_MAX);
		send_sample(S_MIN);
		// Most negative times most negative clips high.
		load_coef(IW'(0), S_MIN);
		send_sample(S_MIN);
		// Two full-scale products nearly cancel, then add up and clip low.
		load_coef(IW'(1), S_MIN);
		send_sample(S_MAX);
		send_sample(S_MAX);
		// Exact half rounds up.
		load_coef(IW'(0), S_MAX);
		load_coef(IW'(1), '0);
		send_sample(16'sd16384);
		load_coef(IW'(0), 16'sd1);
		send_sample(16'sd16384);
		send_sample(-16'sd16384);
		send_sample(-16'sd16385);
		// Highest tap index, then back to an all-zero first tap.
		load_coef(7'd127, S_MIN);
		load_coef(IW'(0), '0);
		send_sample('0);
		wait_drained();

		// Random rounds: a burst of loads, then a stream mostly of samples.
		for (int r = 0; r < 4; r++) begin
			style = r % 3;
			steady <= (r == 2);
			for (int i = 0; i < ROUND_WORDS; i++) begin
				if (r == 1 && i == 40)
					hold_req <= 1'b1;
				if (i < ROUND_LOADS || $urandom_range(99) < 15)
					load_coef(IW'($urandom), rand_coef(style));
				else
					send_sample(rand_sample());
			end
			if (r == 0)
				wait_drained();
		end

		wait_drained();
		repeat (TAPS + 8) @(posedge clk);
		$display("Covered %0d filtered samples and %0d coefficient loads, %0d clipped.",
			samples_sent, loads_sent, saturations);
		$display("Included a %0d-cycle output hold-off and full drains between phases.",
			HOLD_CYCLES);
		if (errors == 0)
			$display("fir_highpass_filter: match");
		else
			$display("fir_highpass_filter: mismatch");
		$finish;
	end

endmodule
